>>> sv/jfsp_pkg.sv
// ----------------------------------------------------------------------------
// jfsp_pkg
// Shared types, marker codes and helper functions for the JPEG frame size
// parser.
// ----------------------------------------------------------------------------
package jfsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic        dims_valid;
    logic [1:0]  parse_status;
    logic [31:0] file_length;
  } out_word_t;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_SKIP      = 4'd1,
    PH_MARK_FF   = 4'd2,
    PH_MARK_CODE = 4'd3,
    PH_LEN_HI    = 4'd4,
    PH_LEN_LO    = 4'd5,
    PH_SOF_BODY  = 4'd6,
    PH_DONE      = 4'd7,
    PH_FAIL      = 4'd8
  } phase_t;

  // parse status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_JFIF   = 2'd1;
  localparam logic [1:0] ST_NO_PREFIX  = 2'd2;
  localparam logic [1:0] ST_NO_FRAME   = 2'd3;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;

  // header layout: soi, app0, two length bytes, "JFIF"
  localparam logic [3:0] HDR_LEN_HI  = 4'd4;
  localparam logic [3:0] HDR_LEN_LO  = 4'd5;
  localparam logic [3:0] HDR_TAG_BEG = 4'd6;
  localparam logic [3:0] HDR_LAST    = 4'd9;
  localparam logic [3:0] HDR_LEN     = 4'd10;

  // frame body offsets: precision, height hi/lo, width hi/lo
  localparam logic [3:0] SOF_H_HI = 4'd1;
  localparam logic [3:0] SOF_H_LO = 4'd2;
  localparam logic [3:0] SOF_W_HI = 4'd3;
  localparam logic [3:0] SOF_W_LO = 4'd4;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  hdr_ofs;
    logic [15:0] skip_rem;
    logic [7:0]  marker;
    logic [7:0]  len_hi;
    logic [15:0] height;
    logic [15:0] width;
    logic [1:0]  outcome;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:    PH_HEADER,
    hdr_ofs:  4'd0,
    skip_rem: 16'd0,
    marker:   8'd0,
    len_hi:   8'd0,
    height:   16'd0,
    width:    16'd0,
    outcome:  ST_NO_FRAME
  };

  function automatic logic [7:0] hdr_byte(input logic [3:0] k);
    logic [7:0] v;
    case (k)
      4'd0:    v = 8'hFF;
      4'd1:    v = 8'hD8;
      4'd2:    v = 8'hFF;
      4'd3:    v = 8'hE0;
      4'd6:    v = 8'h4A;
      4'd7:    v = 8'h46;
      4'd8:    v = 8'h49;
      4'd9:    v = 8'h46;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic is_sof(input logic [7:0] m);
    return m inside {8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC9, 8'hCA, 8'hCB};
  endfunction

  function automatic logic is_standalone(input logic [7:0] m);
    return m inside {8'h01, [8'hD0:8'hD9]};
  endfunction

  // segment length minus the two length bytes, floored at zero
  function automatic logic [15:0] payload_len(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] len;
    len = {hi, lo};
    return (len >= 16'd2) ? len - 16'd2 : 16'd0;
  endfunction

endpackage

>>> sv/jfsp_step.sv
// ----------------------------------------------------------------------------
// jfsp_step
// Next-state logic of the marker walker for one incoming byte.
// ----------------------------------------------------------------------------
module jfsp_step (
  input  jfsp_pkg::parse_state_t cur,
  input  logic [7:0]             data_byte,
  output jfsp_pkg::parse_state_t nxt
);
  import jfsp_pkg::*;

  logic [15:0] skip_dec;

  assign skip_dec = (cur.skip_rem != 16'd0) ? cur.skip_rem - 16'd1 : cur.skip_rem;

  always_comb begin
    logic bad;
    bad = 1'b0;
    nxt = cur;
    case (cur.phase)
      PH_HEADER: begin
        if (cur.hdr_ofs == HDR_LEN_HI) begin
          nxt.len_hi = data_byte;
        end else if (cur.hdr_ofs == HDR_LEN_LO) begin
          nxt.skip_rem = payload_len(cur.len_hi, data_byte);
        end else if (cur.hdr_ofs >= HDR_LEN || data_byte != hdr_byte(cur.hdr_ofs)) begin
          bad = 1'b1;
        end else if (cur.hdr_ofs >= HDR_TAG_BEG) begin
          nxt.skip_rem = skip_dec;
        end
        if (bad) begin
          nxt.outcome = ST_NOT_JFIF;
          nxt.phase   = PH_FAIL;
        end else if (cur.hdr_ofs >= HDR_LAST) begin
          nxt.hdr_ofs = 4'd0;
          nxt.phase   = (nxt.skip_rem != 16'd0) ? PH_SKIP : PH_MARK_FF;
        end else begin
          nxt.hdr_ofs = cur.hdr_ofs + 4'd1;
        end
      end
      PH_SKIP: begin
        nxt.skip_rem = skip_dec;
        if (skip_dec == 16'd0) nxt.phase = PH_MARK_FF;
      end
      PH_MARK_FF: begin
        if (data_byte != MARK_PREFIX) begin
          nxt.outcome = ST_NO_PREFIX;
          nxt.phase   = PH_FAIL;
        end else begin
          nxt.phase = PH_MARK_CODE;
        end
      end
      PH_MARK_CODE: begin
        // fill bytes keep us here
        if (data_byte != MARK_PREFIX) begin
          nxt.marker = data_byte;
          nxt.phase  = is_standalone(data_byte) ? PH_MARK_FF : PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        nxt.len_hi = data_byte;
        nxt.phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (is_sof(cur.marker)) begin
          nxt.hdr_ofs = 4'd0;
          nxt.phase   = PH_SOF_BODY;
        end else begin
          nxt.skip_rem = payload_len(cur.len_hi, data_byte);
          nxt.phase    = (nxt.skip_rem != 16'd0) ? PH_SKIP : PH_MARK_FF;
        end
      end
      PH_SOF_BODY: begin
        case (cur.hdr_ofs)
          SOF_H_HI: nxt.height = {data_byte, 8'd0};
          SOF_H_LO: nxt.height = {cur.height[15:8], data_byte};
          SOF_W_HI: nxt.width  = {data_byte, 8'd0};
          SOF_W_LO: begin
            nxt.width   = {cur.width[15:8], data_byte};
            nxt.outcome = ST_FOUND;
            nxt.phase   = PH_DONE;
          end
          default: ;
        endcase
        nxt.hdr_ofs = cur.hdr_ofs + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/jpeg_frame_size_parser.sv
// ----------------------------------------------------------------------------
// jpeg_frame_size_parser
// Byte-stream JPEG header walker that reports the frame height and width.
// ----------------------------------------------------------------------------
// usage
//   in channel: one word per file byte (data_byte, last_byte); last_byte
//   closes the file. the header must be soi, app0 and the "JFIF" tag; then
//   marker segments are skipped by their length until a start-of-frame
//   marker, whose height and width are captured
//   out channel: exactly one word per file, issued for the word that carries
//   last_byte: sizes, dims_valid, parse_status and the saturated byte count
//   throughput: one byte per cycle; every byte goes through the single
//   next-state step in the cycle it is accepted
//   result: the result word is registered when the last byte is taken
//   stall: the result sits in an output register; in_ready drops only while
//   that register is full and out_ready is low, otherwise bytes keep flowing
//   reset: rst (synchronous) returns the walker to the header check, clears
//   the byte counter and empties the output register
//   after each file the walker restarts on its own for the next one
// ----------------------------------------------------------------------------
module jpeg_frame_size_parser #(
  parameter int LENGTH_COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jfsp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jfsp_pkg::out_word_t out_data
);
  import jfsp_pkg::*;

  localparam logic [LENGTH_COUNT_BITS-1:0] CNT_MAX = {LENGTH_COUNT_BITS{1'b1}};

  parse_state_t                 st;
  parse_state_t                 st_next;
  logic [LENGTH_COUNT_BITS-1:0] cnt;
  logic [LENGTH_COUNT_BITS-1:0] cnt_next;
  logic [31:0]                  len32;
  logic                         accept;
  logic                         ok;
  out_word_t                    result;

  // walker step for the byte on the input
  jfsp_step u_step (
    .cur       (st),
    .data_byte (in_data.data_byte),
    .nxt       (st_next)
  );

  // output register frees up when empty or drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // saturating byte count, including this byte
  assign cnt_next = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;

  // report count clipped to 32 bits
  generate
    if (LENGTH_COUNT_BITS > 32) begin : g_clip
      assign len32 = (|cnt_next[LENGTH_COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : cnt_next[31:0];
    end else begin : g_ext
      assign len32 = 32'(cnt_next);
    end
  endgenerate

  // result word from the state after this byte
  assign ok = (st_next.outcome == ST_FOUND);
  always_comb begin
    result.frame_height = ok ? st_next.height : 16'd0;
    result.frame_width  = ok ? st_next.width  : 16'd0;
    result.dims_valid   = ok && (st_next.height != 16'd0) && (st_next.width != 16'd0);
    result.parse_status = st_next.outcome;
    result.file_length  = len32;
  end

  // walker state and byte counter; a closing byte restarts both
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= STATE_RESET;
      cnt <= '0;
    end else if (accept) begin
      if (in_data.last_byte) begin
        st  <= STATE_RESET;
        cnt <= '0;
      end else begin
        st  <= st_next;
        cnt <= cnt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data <= result;
    end
  end

  // a closing byte always produces a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_byte |=> out_valid)
    else $error("closing byte produced no result");

  // a closing byte returns the walker to the header check
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_byte |=> st.phase == PH_HEADER && cnt == '0)
    else $error("walker not restarted after closing byte");

  // valid sizes only with a found frame
  a_dims_need_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dims_valid |-> out_data.parse_status == ST_FOUND)
    else $error("dims_valid without found status");

  // failed parse reports zero sizes
  a_fail_zero_dims: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.parse_status != ST_FOUND |->
      out_data.frame_height == 16'd0 && out_data.frame_width == 16'd0)
    else $error("nonzero sizes on failed parse");

endmodule

>>> sim/jpeg_frame_size_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpeg_frame_size_parser_tb
// Streams byte-wide JPEG files into the frame size parser and checks each
// per-file report against an in-bench header walker. Short hand-built files
// come first, then random files, mostly well formed with some damaged.
// ----------------------------------------------------------------------------
module jpeg_frame_size_parser_tb;
  import jfsp_pkg::*;

  // run control
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1300;
  localparam int RANDOM_FILES = 30;
  localparam int IDLE_PCT     = 26;

  // marker codes used to build files
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_APP0   = 8'hE0;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_COM    = 8'hFE;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOF1   = 8'hC1;
  localparam logic [7:0] MK_SOF2   = 8'hC2;
  localparam logic [7:0] MK_SOF3   = 8'hC3;
  localparam logic [7:0] MK_SOF9   = 8'hC9;
  localparam logic [7:0] MK_SOF10  = 8'hCA;
  localparam logic [7:0] MK_SOF11  = 8'hCB;
  localparam logic [7:0] PRECISION = 8'h08;

  localparam logic [31:0] JFIF_TAG = "JFIF";
  // expected opening bytes; the two length bytes are not compared
  localparam logic [0:9][7:0] JFIF_OPEN = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_APP0,
                                           16'h0000, JFIF_TAG};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // walker copy of the block state
  phase_t      walk_phase;
  logic [3:0]  walk_ofs;
  logic [15:0] walk_skip;
  logic [7:0]  walk_marker;
  logic [7:0]  walk_len_hi;
  logic [15:0] walk_height;
  logic [15:0] walk_width;
  logic [31:0] walk_count;
  logic [1:0]  walk_status;

  out_word_t  reports_due[$];   // one pending report per finished file
  logic [7:0] file_bytes[$];    // file under construction
  out_word_t  want;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         files_sent = 0;
  bit         steady_flow = 1'b0;  // no idling on either side while set

  jpeg_frame_size_parser #(
    .LENGTH_COUNT_BITS(32)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- walker

  function automatic bit code_stands_alone(input logic [7:0] m);
    return m == MK_TEM || (m >= MK_RST0 && m <= MK_EOI);
  endfunction

  function automatic bit code_opens_frame(input logic [7:0] m);
    case (m)
      MK_SOF0, MK_SOF1, MK_SOF2, MK_SOF3, MK_SOF9, MK_SOF10, MK_SOF11: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic walk_restart();
    walk_phase  = PH_HEADER;
    walk_ofs    = '0;
    walk_skip   = '0;
    walk_marker = '0;
    walk_len_hi = '0;
    walk_height = '0;
    walk_width  = '0;
    walk_count  = '0;
    walk_status = ST_NO_FRAME;
  endtask

  // advance the walker by one accepted byte; queue a report on the last one
  task automatic track_parse(input logic [7:0] b, input logic last);
    logic [15:0] seg_len;
    logic [15:0] body_len;
    logic [3:0]  k;
    out_word_t   rpt;
    seg_len  = {walk_len_hi, b};
    body_len = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
    k        = walk_ofs;
    if (walk_count != '1) walk_count++;
    case (walk_phase)
      PH_HEADER: begin
        if (k == 4'd4) begin
          walk_len_hi = b;
        end else if (k == 4'd5) begin
          walk_skip = body_len;
        end else if (k > 4'd9 || b != JFIF_OPEN[k]) begin
          walk_status = ST_NOT_JFIF;
          walk_phase  = PH_FAIL;
        end else if (k >= 4'd6 && walk_skip != 0) begin
          walk_skip--;  // tag bytes count against the app0 length
        end
        if (walk_phase == PH_HEADER) begin
          if (k >= 4'd9) begin
            walk_ofs   = '0;
            walk_phase = (walk_skip != 0) ? PH_SKIP : PH_MARK_FF;
          end else begin
            walk_ofs = k + 4'd1;
          end
        end
      end
      PH_SKIP: begin
        if (walk_skip != 0) walk_skip--;
        if (walk_skip == 0) walk_phase = PH_MARK_FF;
      end
      PH_MARK_FF: begin
        if (b != MK_PREFIX) begin
          walk_status = ST_NO_PREFIX;
          walk_phase  = PH_FAIL;
        end else begin
          walk_phase = PH_MARK_CODE;
        end
      end
      PH_MARK_CODE: begin
        // fill bytes leave the walker waiting for the code
        if (b != MK_PREFIX) begin
          walk_marker = b;
          walk_phase  = code_stands_alone(b) ? PH_MARK_FF : PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        walk_len_hi = b;
        walk_phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (code_opens_frame(walk_marker)) begin
          walk_ofs   = '0;
          walk_phase = PH_SOF_BODY;
        end else begin
          walk_skip  = body_len;
          walk_phase = (body_len != 0) ? PH_SKIP : PH_MARK_FF;
        end
      end
      PH_SOF_BODY: begin
        // offset 0 is the precision byte
        case (walk_ofs)
          4'd1: walk_height[15:8] = b;
          4'd2: walk_height[7:0]  = b;
          4'd3: walk_width[15:8]  = b;
          4'd4: begin
            walk_width[7:0] = b;
            walk_status     = ST_FOUND;
            walk_phase      = PH_DONE;
          end
          default: ;
        endcase
        walk_ofs = walk_ofs + 4'd1;
      end
      default: ;  // done or failed: only the count moves
    endcase
    if (last) begin
      rpt.frame_height = (walk_status == ST_FOUND) ? walk_height : 16'd0;
      rpt.frame_width  = (walk_status == ST_FOUND) ? walk_width : 16'd0;
      rpt.dims_valid   = rpt.frame_height != 0 && rpt.frame_width != 0;
      rpt.parse_status = walk_status;
      rpt.file_length  = walk_count;
      reports_due.push_back(rpt);
      walk_restart();
    end
  endtask

  // ---------------------------------------------------------------- driving

  // present one word, hold it until taken, then feed the walker
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_parse(b, last);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  // ---------------------------------------------------------------- file building

  task automatic put(input logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic put_random(input int n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endtask

  // soi, app0, length and tag; the caller adds any app0 body
  task automatic put_header(input logic [15:0] app_len);
    put(MK_PREFIX); put(MK_SOI); put(MK_PREFIX); put(MK_APP0);
    put(app_len[15:8]); put(app_len[7:0]);
    for (int i = 3; i >= 0; i--) put(JFIF_TAG[8*i +: 8]);
  endtask

  task automatic put_segment(input logic [7:0] code, input logic [15:0] seg_len);
    put(MK_PREFIX);
    put(code);
    if (!code_stands_alone(code)) begin
      put(seg_len[15:8]);
      put(seg_len[7:0]);
      put_random((seg_len >= 16'd2) ? seg_len - 16'd2 : 0);
    end
  endtask

  task automatic put_frame(input logic [7:0] code, input logic [15:0] seg_len,
                           input logic [15:0] h, input logic [15:0] w);
    put(MK_PREFIX); put(code);
    put(seg_len[15:8]); put(seg_len[7:0]);
    put(PRECISION);
    put(h[15:8]); put(h[7:0]);
    put(w[15:8]); put(w[7:0]);
  endtask

  function automatic logic [7:0] frame_code();
    case ($urandom_range(0, 6))
      0: return MK_SOF0;
      1: return MK_SOF1;
      2: return MK_SOF2;
      3: return MK_SOF3;
      4: return MK_SOF9;
      5: return MK_SOF10;
      default: return MK_SOF11;
    endcase
  endfunction

  // any marker code that is neither a fill byte nor a frame marker
  function automatic logic [7:0] plain_code();
    logic [7:0] m;
    if ($urandom_range(0, 99) < 20)
      return ($urandom_range(0, 10) == 0) ? MK_TEM : MK_RST0 + 8'($urandom_range(0, 9));
    m = MK_PREFIX;
    while (m == MK_PREFIX || code_opens_frame(m)) m = 8'($urandom_range(0, 255));
    return m;
  endfunction

  function automatic logic [15:0] random_size();
    return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
  endfunction

  task automatic build_random_file();
    logic [15:0] app_len;
    int          pos;
    // short noise files
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) put(MK_PREFIX);
      put_random($urandom_range(1, 5));
      return;
    end
    app_len = ($urandom_range(0, 99) < 75) ? 16'd16 : 16'($urandom_range(0, 9));
    put_header(app_len);
    put_random((app_len >= 16'd6) ? app_len - 16'd6 : 0);
    repeat ($urandom_range(0, 3)) begin
      repeat (($urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0) put(MK_PREFIX);
      if ($urandom_range(0, 99) < 4) begin
        // comment segment with a random length; the file ends at most four bytes after the length
        put(MK_PREFIX); put(MK_COM);
        put_random(2 + $urandom_range(0, 4));
        return;
      end
      put_segment(plain_code(), ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                           : 16'($urandom_range(2, 10)));
    end
    put_frame(frame_code(), $urandom_range(0, 1) ? 16'd17 : 16'($urandom_range(0, 65535)),
              random_size(), random_size());
    put_random($urandom_range(0, 2));
    // damage about a quarter of the files
    if ($urandom_range(0, 99) < 25) begin
      pos = $urandom_range(0, file_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: while (file_bytes.size() > pos + 1) void'(file_bytes.pop_back());
        1: file_bytes[pos] = 8'($urandom_range(0, 255));
        default: file_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_single_byte_files();
    put(MK_PREFIX);
    send_file();
    put(8'h00);
    send_file();
  endtask

  task automatic test_found_extremes();
    // app0 length below 2: marker follows the tag at once; frame length 0 unchecked
    put_header(16'h0000);
    put_frame(MK_SOF0, 16'h0000, 16'hFFFF, 16'hFFFF);
    put(MK_PREFIX); put(8'h00);  // after the sizes only the count moves
    send_file();
    // app0 length 7 leaves one body byte; zero height clears dims_valid
    put_header(16'd7);
    put_random(1);
    put_frame(MK_SOF11, 16'hFFFF, 16'h0000, 16'h0001);
    send_file();
  endtask

  task automatic test_fill_and_standalone();
    put_header(16'd6);
    put(MK_PREFIX); put(MK_PREFIX);       // fill bytes ahead of a code
    put_segment(MK_SOI, 16'd0);
    put_segment(MK_TEM, 16'd0);
    put_segment(MK_RST0, 16'd0);
    put_segment(MK_EOI, 16'd0);
    put_segment(MK_COM, 16'd1);           // below 2 skips nothing
    put_segment(MK_DHT, 16'd3);
    put_frame(MK_SOF1, 16'd17, 16'd480, 16'd640);
    send_file();
  endtask

  task automatic test_failure_codes();
    // wrong tag byte
    put_header(16'd16);
    file_bytes[9] = 8'h00;
    put_random(3);
    send_file();
    // soi missing
    put(MK_PREFIX); put(MK_EOI); put(MK_PREFIX);
    send_file();
    // segment start without prefix
    put_header(16'd6);
    put(8'h00); put(MK_PREFIX); put(MK_SOF0);
    send_file();
    // file ends inside the frame sizes
    put_header(16'd1);
    put_frame(MK_SOF2, 16'd17, 16'h1234, 16'h5678);
    void'(file_bytes.pop_back());
    send_file();
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (12) begin
      build_random_file();
      send_file();
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_files();
    int first_byte;
    int first_file;
    first_byte = bytes_sent;
    first_file = files_sent;
    while (bytes_sent - first_byte < RANDOM_BYTES || files_sent - first_file < RANDOM_FILES) begin
      build_random_file();
      send_file();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  // result side: check each taken report, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        report_mismatch("report with no file pending");
      end else begin
        want = reports_due.pop_front();
        if (out_data.frame_height !== want.frame_height)
          report_mismatch($sformatf("frame_height %0d, want %0d",
                                    out_data.frame_height, want.frame_height));
        if (out_data.frame_width !== want.frame_width)
          report_mismatch($sformatf("frame_width %0d, want %0d",
                                    out_data.frame_width, want.frame_width));
        if (out_data.dims_valid !== want.dims_valid)
          report_mismatch($sformatf("dims_valid %b, want %b",
                                    out_data.dims_valid, want.dims_valid));
        if (out_data.parse_status !== want.parse_status)
          report_mismatch($sformatf("parse_status %0d, want %0d",
                                    out_data.parse_status, want.parse_status));
        if (out_data.file_length !== want.file_length)
          report_mismatch($sformatf("file_length %0d, want %0d",
                                    out_data.file_length, want.file_length));
      end
    end
    out_ready <= steady_flow || $urandom_range(0, 99) >= IDLE_PCT;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("jpeg_frame_size_parser_tb NOT OK");
    $finish;
  end

  initial begin
    walk_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_single_byte_files();
    test_found_extremes();
    test_fill_and_standalone();
    test_failure_codes();
    test_back_to_back();
    test_random_files();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    // catch any stray report after the last one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("jpeg_frame_size_parser_tb OK");
    else
      $display("jpeg_frame_size_parser_tb NOT OK");
    $finish;
  end

endmodule
